// ===== rtl/core/scomp_pkg.sv =====
// ----------------------------------------------------------------------------
// scomp_pkg
// Shared types, constants and small multiply helpers for the sensor
// reading compensation pipeline.
// ----------------------------------------------------------------------------
package scomp_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] CFG_HAS_HUM  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEMP     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LO = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HI = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIXED    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HUM      = 3'd5;

  // pipeline depths
  localparam int unsigned TempLat  = 4;
  localparam int unsigned PreLat   = 8;
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 31;
  localparam int unsigned PostLat  = 6;
  localparam int unsigned PressLat = PreLat + DivNumW + PostLat;
  localparam int unsigned HumLat   = 10;
  localparam int unsigned TotalLat = TempLat + PressLat;

  // formula constants
  localparam logic [32:0] TfineOffP   = 33'd128000;
  localparam logic [31:0] TfineOffH   = 32'd76800;
  localparam logic [20:0] RawPFull    = 21'd1048576;
  localparam logic [11:0] PressScale  = 12'd3125;
  localparam logic [63:0] PressBias   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HumOffA     = 32'd32768;
  localparam logic [31:0] HumOffB     = 32'd2097152;
  localparam logic [31:0] HumRoundB   = 32'd8192;
  localparam logic [31:0] HumMaxQ     = 32'd419430400;
  localparam logic [31:0] TempRound   = 32'd128;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
    logic               humidity_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } div_side_t;

  // low word of a 64x16 product: exact 33x16 signed partial
  function automatic logic signed [48:0] mul_lo(input logic [31:0] a,
                                                input logic signed [15:0] b);
    logic signed [32:0] as;
    as = $signed({1'b0, a});
    return as * b;
  endfunction

  // high word of a 64x16 product, modulo 2^32
  function automatic logic [31:0] mul_hi(input logic [31:0] a,
                                         input logic signed [15:0] b);
    logic [31:0] bx;
    bx = 32'(b);
    return a * bx;
  endfunction

  function automatic logic [63:0] join_parts(input logic signed [48:0] lo,
                                             input logic [31:0] hi);
    return 64'(lo) + {hi, 32'h0};
  endfunction

endpackage

// ===== rtl/core/scomp_stream_if.sv =====
// ----------------------------------------------------------------------------
// scomp_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface scomp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/scomp_delay.sv =====
// ----------------------------------------------------------------------------
// scomp_delay
// Enabled shift line that keeps side results aligned with the pipeline.
// ----------------------------------------------------------------------------
module scomp_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned Depth = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign q_o = line_q[Depth-1];

endmodule

// ===== rtl/core/scomp_temp.sv =====
// ----------------------------------------------------------------------------
// scomp_temp
// Four-stage temperature compensation: fine temperature and 0.01 degC.
// ----------------------------------------------------------------------------
module scomp_temp (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [19:0]        raw_t_i,
  input  scomp_pkg::cal_t    cal_i,
  output logic [31:0]        tfine_o,
  output logic signed [31:0] temp_o
);

  logic signed [17:0] diff_a;
  logic signed [16:0] diff_d;
  logic signed [33:0] prod_a;
  logic signed [33:0] dsq_full;
  logic [31:0]        a_prod_q, dsq_q;

  logic [31:0]        a_d, dsh;
  logic signed [35:0] b_full;
  logic [31:0]        a_q, b_prod_q;

  logic [31:0]        tfine_d, tfine_q;
  logic [31:0]        t5;
  logic [31:0]        temp_d;
  logic [31:0]        tfine_out_q, temp_q;

  // stage 1
  always_comb begin
    diff_a   = $signed({1'b0, raw_t_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
    diff_d   = $signed({1'b0, raw_t_i[19:4]}) - $signed({1'b0, cal_i.t1});
    prod_a   = diff_a * $signed(cal_i.t2);
    dsq_full = diff_d * diff_d;
  end

  // stage 2
  always_comb begin
    a_d    = $signed(a_prod_q) >>> 11;
    dsh    = $signed(dsq_q) >>> 12;
    b_full = $signed(dsh[19:0]) * $signed(cal_i.t3);
  end

  // stage 3 and 4
  always_comb begin
    tfine_d = a_q + 32'($signed(b_prod_q) >>> 14);
    t5      = tfine_q + {tfine_q[29:0], 2'b00} + scomp_pkg::TempRound;
    temp_d  = $signed(t5) >>> 8;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_prod_q    <= prod_a[31:0];
      dsq_q       <= dsq_full[31:0];
      a_q         <= a_d;
      b_prod_q    <= b_full[31:0];
      tfine_q     <= tfine_d;
      tfine_out_q <= tfine_q;
      temp_q      <= temp_d;
    end
  end

  assign tfine_o = tfine_out_q;
  assign temp_o  = $signed(temp_q);

endmodule

// ===== rtl/core/scomp_hum.sv =====
// ----------------------------------------------------------------------------
// scomp_hum
// Ten-stage humidity compensation in 32-bit wrapping arithmetic, Q22.10.
// ----------------------------------------------------------------------------
module scomp_hum (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [31:0]     tfine_i,
  input  logic [15:0]     raw_h_i,
  input  scomp_pkg::cal_t cal_i,
  output logic [16:0]     hum_o
);

  logic [31:0] h4x, h5x, h6x, h2x, h3x, h1x;
  logic [31:0] v_q;
  logic [15:0] raw_h1_q, raw_h2_q;
  logic [31:0] h5v_q, vh6_q, vh3_q;
  logic [31:0] x_d, f1_d, f2_d;
  logic [31:0] x3_q, f1_q, f2_q;
  logic [31:0] x4_q, y1_q;
  logic [31:0] x5_q, y2_q;
  logic [31:0] x6_q, y3_q;
  logic [31:0] y2_d, y3_d;
  logic [31:0] vv_q, vv8_q, vv9_q;
  logic [16:0] s17;
  logic signed [33:0] ss_full;
  logic [31:0] ss_q, sh7, t_q;
  logic [31:0] r, r_c;
  logic [16:0] hum_q;

  always_comb begin
    h1x = {24'h0, cal_i.h1};
    h2x = 32'(cal_i.h2);
    h3x = {24'h0, cal_i.h3};
    h4x = 32'(cal_i.h4);
    h5x = 32'(cal_i.h5);
    h6x = 32'(cal_i.h6);
  end

  always_comb begin
    x_d  = $signed({2'b00, raw_h2_q, 14'h0} - {h4x[11:0], 20'h0} - h5v_q
                   + scomp_pkg::HumRound) >>> 15;
    f1_d = $signed(vh6_q) >>> 10;
    f2_d = 32'($signed(vh3_q) >>> 11) + scomp_pkg::HumOffA;
    y2_d = 32'($signed(y1_q) >>> 10) + scomp_pkg::HumOffB;
    y3_d = $signed(y2_q * h2x + scomp_pkg::HumRoundB) >>> 14;
    s17     = vv_q[31:15];
    ss_full = $signed(s17) * $signed(s17);
    sh7     = $signed(ss_q) >>> 7;
  end

  // final correction and clamp to 0..100 %RH
  always_comb begin
    r = vv9_q - 32'($signed(t_q) >>> 4);
    if (r[31]) begin
      r_c = '0;
    end else if (r > scomp_pkg::HumMaxQ) begin
      r_c = scomp_pkg::HumMaxQ;
    end else begin
      r_c = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q      <= tfine_i - scomp_pkg::TfineOffH;
      raw_h1_q <= raw_h_i;
      h5v_q    <= v_q * h5x;
      vh6_q    <= v_q * h6x;
      vh3_q    <= v_q * h3x;
      raw_h2_q <= raw_h1_q;
      x3_q     <= x_d;
      f1_q     <= f1_d;
      f2_q     <= f2_d;
      x4_q     <= x3_q;
      y1_q     <= f1_q * f2_q;
      x5_q     <= x4_q;
      y2_q     <= y2_d;
      x6_q     <= x5_q;
      y3_q     <= y3_d;
      vv_q     <= x6_q * y3_q;
      vv8_q    <= vv_q;
      ss_q     <= ss_full[31:0];
      vv9_q    <= vv8_q;
      t_q      <= sh7 * h1x;
      hum_q    <= r_c[28:12];
    end
  end

  assign hum_o = hum_q;

endmodule

// ===== rtl/core/scomp_div.sv =====
// ----------------------------------------------------------------------------
// scomp_div
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module scomp_div #(
  parameter int unsigned NumW = scomp_pkg::DivNumW,
  parameter int unsigned DenW = scomp_pkg::DivDenW
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NumW-1:0]      num_i,
  input  logic [DenW-1:0]      den_i,
  input  scomp_pkg::div_side_t side_i,
  output logic [NumW-1:0]      quo_o,
  output scomp_pkg::div_side_t side_o
);

  // numerator bits shift out at the top while quotient bits enter below
  logic [NumW-1:0]      nq_q   [NumW];
  logic [DenW-1:0]      rem_q  [NumW-1];
  logic [DenW-1:0]      den_q  [NumW-1];
  scomp_pkg::div_side_t side_q [NumW];

  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic [NumW-1:0]      nq_in;
    logic [DenW-1:0]      rem_in;
    logic [DenW-1:0]      den_in;
    scomp_pkg::div_side_t side_in;
    logic [DenW:0]        trial;
    logic [DenW:0]        diff;
    logic                 take;

    if (g == 0) begin : g_first
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign nq_in   = nq_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = {rem_in, nq_in[NumW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[g]   <= {nq_in[NumW-2:0], take};
        side_q[g] <= side_in;
      end
    end

    if (g < NumW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= take ? diff[DenW-1:0] : trial[DenW-1:0];
          den_q[g] <= den_in;
        end
      end
    end
  end

  assign quo_o  = nq_q[NumW-1];
  assign side_o = side_q[NumW-1];

endmodule

// ===== rtl/core/scomp_press.sv =====
// ----------------------------------------------------------------------------
// scomp_press
// Pressure compensation: 64-bit coefficient stages, pipelined signed
// division and the final correction, giving Q24.8 pascal.
// ----------------------------------------------------------------------------
module scomp_press (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [31:0]     tfine_i,
  input  logic [19:0]     raw_p_i,
  input  scomp_pkg::cal_t cal_i,
  output logic [31:0]     press_o,
  output logic            pvalid_o
);

  // ---- before the division
  logic signed [32:0] v1_q;
  logic [19:0]        rp1_q, rp2_q, rp3_q, rp4_q;
  logic signed [65:0] sq_full;
  logic [63:0]        sq_q;
  logic signed [48:0] m5_q, m2_q, m5b_q, m2b_q;
  logic signed [48:0] a6lo_q, a3lo_q;
  logic [31:0]        a6hi_q, a3hi_q;
  logic [63:0]        v2_d, v1b, w_d;
  logic [63:0]        v2_q, w_q;
  logic [47:0]        wlo_q;
  logic [31:0]        whi_q;
  logic [63:0]        n0_d, n0_q;
  logic [63:0]        vsum;
  logic [30:0]        v1c_q;
  logic [43:0]        nlo_q;
  logic [31:0]        nhi_q;
  logic [63:0]        num_q;
  logic [30:0]        ud_q, ud8_q;
  logic               dneg_q, zero_q;
  logic [63:0]        un_q;
  scomp_pkg::div_side_t side8_q;

  // ---- after the division
  logic [63:0]          quo;
  scomp_pkg::div_side_t side_div;
  logic [63:0]          p1_q, p2_q, p3_q, p4_q, p5_q;
  logic                 z1_q, z2_q, z3_q, z4_q, z5_q;
  logic [31:0]          sl;
  logic signed [18:0]   sh;
  logic [63:0]          ll_q;
  logic [31:0]          lh_q;
  logic signed [48:0]   pp8lo_q, s9lo_q;
  logic [31:0]          pp8hi_q, s9hi_q;
  logic [63:0]          ss_q, v2p_q, v2p4_q, v2p5_q, v1p_q;
  logic [39:0]          sum40;
  logic [31:0]          res;
  logic [31:0]          press_q;
  logic                 pvalid_q;

  always_comb begin
    sq_full = v1_q * v1_q;
    v2_d = scomp_pkg::join_parts(a6lo_q, a6hi_q) + (64'(m5b_q) << 17)
         + (64'(cal_i.p4) << 35);
    v1b  = 64'($signed(scomp_pkg::join_parts(a3lo_q, a3hi_q)) >>> 8)
         + (64'(m2b_q) << 12);
    w_d  = scomp_pkg::PressBias + v1b;
    n0_d = {12'h0, 21'(scomp_pkg::RawPFull - {1'b0, rp4_q}), 31'h0} - v2_q;
    vsum = {whi_q, 32'h0} + {16'h0, wlo_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 1
      v1_q    <= $signed({tfine_i[31], tfine_i}) - $signed(scomp_pkg::TfineOffP);
      rp1_q   <= raw_p_i;
      // 2
      sq_q    <= sq_full[63:0];
      m5_q    <= v1_q * $signed(cal_i.p5);
      m2_q    <= v1_q * $signed(cal_i.p2);
      rp2_q   <= rp1_q;
      // 3
      a6lo_q  <= scomp_pkg::mul_lo(sq_q[31:0], cal_i.p6);
      a6hi_q  <= scomp_pkg::mul_hi(sq_q[63:32], cal_i.p6);
      a3lo_q  <= scomp_pkg::mul_lo(sq_q[31:0], cal_i.p3);
      a3hi_q  <= scomp_pkg::mul_hi(sq_q[63:32], cal_i.p3);
      m5b_q   <= m5_q;
      m2b_q   <= m2_q;
      rp3_q   <= rp2_q;
      // 4
      v2_q    <= v2_d;
      w_q     <= w_d;
      rp4_q   <= rp3_q;
      // 5
      wlo_q   <= w_q[31:0] * cal_i.p1;
      whi_q   <= w_q[63:32] * {16'h0, cal_i.p1};
      n0_q    <= n0_d;
      // 6: divisor is the arithmetic shift by 33, it fits 31 bits
      v1c_q   <= vsum[63:33];
      nlo_q   <= n0_q[31:0] * scomp_pkg::PressScale;
      nhi_q   <= n0_q[63:32] * {20'h0, scomp_pkg::PressScale};
      // 7
      num_q   <= {20'h0, nlo_q} + {nhi_q, 32'h0};
      ud_q    <= v1c_q[30] ? (31'd0 - v1c_q) : v1c_q;
      dneg_q  <= v1c_q[30];
      zero_q  <= (v1c_q == '0);
      // 8: magnitudes into the divider, sign of the quotient alongside
      un_q         <= num_q[63] ? (64'd0 - num_q) : num_q;
      ud8_q        <= ud_q;
      side8_q.neg  <= num_q[63] ^ dneg_q;
      side8_q.zero <= zero_q;
    end
  end

  scomp_div #(
    .NumW(scomp_pkg::DivNumW),
    .DenW(scomp_pkg::DivDenW)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (un_q),
    .den_i (ud8_q),
    .side_i(side8_q),
    .quo_o (quo),
    .side_o(side_div)
  );

  always_comb begin
    sl    = p1_q[44:13];
    sh    = $signed(p1_q[63:45]);
    sum40 = p5_q[39:0] + v1p_q[39:0] + v2p5_q[39:0];
    res   = sum40[39:8] + 32'($signed({cal_i.p7, 4'h0}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 1
      p1_q    <= side_div.neg ? (64'd0 - quo) : quo;
      z1_q    <= side_div.zero;
      // 2: square of p >>> 13 split in 32-bit halves, and p * P8
      ll_q    <= sl * sl;
      lh_q    <= sl * 32'(sh);
      pp8lo_q <= scomp_pkg::mul_lo(p1_q[31:0], cal_i.p8);
      pp8hi_q <= scomp_pkg::mul_hi(p1_q[63:32], cal_i.p8);
      p2_q    <= p1_q;
      z2_q    <= z1_q;
      // 3
      ss_q    <= ll_q + {lh_q[30:0], 33'h0};
      v2p_q   <= 64'($signed(scomp_pkg::join_parts(pp8lo_q, pp8hi_q)) >>> 19);
      p3_q    <= p2_q;
      z3_q    <= z2_q;
      // 4
      s9lo_q  <= scomp_pkg::mul_lo(ss_q[31:0], cal_i.p9);
      s9hi_q  <= scomp_pkg::mul_hi(ss_q[63:32], cal_i.p9);
      v2p4_q  <= v2p_q;
      p4_q    <= p3_q;
      z4_q    <= z3_q;
      // 5
      v1p_q   <= 64'($signed(scomp_pkg::join_parts(s9lo_q, s9hi_q)) >>> 25);
      v2p5_q  <= v2p4_q;
      p5_q    <= p4_q;
      z5_q    <= z4_q;
      // 6
      press_q  <= z5_q ? 32'h0 : res;
      pvalid_q <= ~z5_q;
    end
  end

  assign press_o  = press_q;
  assign pvalid_o = pvalid_q;

endmodule

// ===== rtl/core/sensor_reading_compensation_top.sv =====
// ----------------------------------------------------------------------------
// sensor_reading_compensation_top
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// Accepts one raw sample triple per clock and returns one compensated result
// per triple, in order, after 4 temperature stages, 8 pressure coefficient
// stages, the 64-stage restoring divider of the pressure formula and 6 final
// pressure stages. The whole pipeline moves as one: while a finished result
// waits at the output, every stage holds and req_i.ready is low; otherwise a
// new triple enters every cycle. The user must write calibration words
// through cfg_we_i/cfg_idx_i/cfg_data_i only while no request is in flight;
// the block itself does not enforce this. Indexes above 5 are ignored.
module sensor_reading_compensation_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  scomp_stream_if.sink                         req_i,
  scomp_stream_if.source                       res_o,
  input  logic                                 cfg_we_i,
  input  logic [scomp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [scomp_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned Last = scomp_pkg::TotalLat - 1;

  logic        has_hum_q;
  logic [47:0] temp_cal_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [47:0] mixed_cal_q;
  logic [31:0] hum_cal_q;

  scomp_pkg::cal_t cal;

  logic [scomp_pkg::TotalLat-1:0] vld_q;
  logic        en;

  logic [31:0]        tfine;
  logic signed [31:0] temp;
  logic [31:0]        temp_dly;
  logic [19:0]        raw_p_dly;
  logic [15:0]        raw_h_dly;
  logic [16:0]        hum;
  logic [16:0]        hum_dly;
  logic [31:0]        press;
  logic               pvalid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_hum_q   <= 1'b1;
      temp_cal_q  <= '0;
      press_lo_q  <= '0;
      press_hi_q  <= '0;
      mixed_cal_q <= '0;
      hum_cal_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scomp_pkg::CFG_HAS_HUM:  has_hum_q   <= cfg_data_i[0];
        scomp_pkg::CFG_TEMP:     temp_cal_q  <= cfg_data_i[47:0];
        scomp_pkg::CFG_PRESS_LO: press_lo_q  <= cfg_data_i;
        scomp_pkg::CFG_PRESS_HI: press_hi_q  <= cfg_data_i;
        scomp_pkg::CFG_MIXED:    mixed_cal_q <= cfg_data_i[47:0];
        scomp_pkg::CFG_HUM:      hum_cal_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_q[15:0];
    cal.t2 = $signed(temp_cal_q[31:16]);
    cal.t3 = $signed(temp_cal_q[47:32]);
    cal.p1 = press_lo_q[15:0];
    cal.p2 = $signed(press_lo_q[31:16]);
    cal.p3 = $signed(press_lo_q[47:32]);
    cal.p4 = $signed(press_lo_q[63:48]);
    cal.p5 = $signed(press_hi_q[15:0]);
    cal.p6 = $signed(press_hi_q[31:16]);
    cal.p7 = $signed(press_hi_q[47:32]);
    cal.p8 = $signed(press_hi_q[63:48]);
    cal.p9 = $signed(mixed_cal_q[15:0]);
    cal.h1 = mixed_cal_q[23:16];
    cal.h2 = $signed(mixed_cal_q[39:24]);
    cal.h3 = mixed_cal_q[47:40];
    cal.h4 = $signed(hum_cal_q[11:0]);
    cal.h5 = $signed(hum_cal_q[23:12]);
    cal.h6 = $signed(hum_cal_q[31:24]);
  end

  // global pipeline advance: stall only when the output holds a result that is not taken
  assign en          = ~vld_q[Last] | res_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], req_i.valid};
    end
  end

  scomp_temp u_temp (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_t_i(req_i.data.raw_temperature),
    .cal_i  (cal),
    .tfine_o(tfine),
    .temp_o (temp)
  );

  scomp_delay #(.W(20), .Depth(scomp_pkg::TempLat)) u_dly_rawp (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (req_i.data.raw_pressure),
    .q_o  (raw_p_dly)
  );

  scomp_delay #(.W(16), .Depth(scomp_pkg::TempLat)) u_dly_rawh (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (req_i.data.raw_humidity),
    .q_o  (raw_h_dly)
  );

  scomp_press u_press (
    .clk_i   (clk_i),
    .en_i    (en),
    .tfine_i (tfine),
    .raw_p_i (raw_p_dly),
    .cal_i   (cal),
    .press_o (press),
    .pvalid_o(pvalid)
  );

  scomp_hum u_hum (
    .clk_i  (clk_i),
    .en_i   (en),
    .tfine_i(tfine),
    .raw_h_i(raw_h_dly),
    .cal_i  (cal),
    .hum_o  (hum)
  );

  scomp_delay #(.W(32), .Depth(scomp_pkg::PressLat)) u_dly_temp (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (temp),
    .q_o  (temp_dly)
  );

  scomp_delay #(.W(17), .Depth(scomp_pkg::PressLat - scomp_pkg::HumLat)) u_dly_hum (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (hum),
    .q_o  (hum_dly)
  );

  assign res_o.valid                  = vld_q[Last];
  assign res_o.data.temperature_centi = $signed(temp_dly);
  assign res_o.data.pressure_q24_8    = press;
  assign res_o.data.pressure_valid    = pvalid;
  assign res_o.data.humidity_q22_10   = has_hum_q ? hum_dly : 17'h0;
  assign res_o.data.humidity_valid    = has_hum_q;

endmodule

// ===== dv/tb_sensor_reading_compensation_top.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_reading_compensation_top
// Self-checking bench for the sensor reading compensation pipeline. Raw
// sample triples are streamed under several calibration sets. Each result is
// checked against an in-bench integer compensation computed at request time.
// ----------------------------------------------------------------------------
module tb_sensor_reading_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scomp_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned HoldCycles = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_HAS_HUM;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  scomp_stream_if #(.T(in_item_t))  req_if ();
  scomp_stream_if #(.T(out_item_t)) res_if ();

  sensor_reading_compensation_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .res_o     (res_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // shadow calibration
  logic        cal_has_hum = 1'b1;
  logic [47:0] cal_temp    = '0;
  logic [63:0] cal_plo     = '0;
  logic [63:0] cal_phi     = '0;
  logic [47:0] cal_mixed   = '0;
  logic [31:0] cal_hum     = '0;

  in_item_t  pending_samples[$];
  out_item_t expected_readings[$];
  int unsigned errors = 0;
  bit no_idle = 1'b0;
  bit hold_go = 1'b0;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] sdiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q  = un / ud;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic out_item_t compensate(input in_item_t s);
    out_item_t   r;
    logic [31:0] adc_t, adc_h, t1, t2, t3, a, d, b, tfine;
    logic [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hs;
    logic [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, nv1, p, ps;
    adc_t = {12'd0, s.raw_temperature};
    adc_p = {44'd0, s.raw_pressure};
    adc_h = {16'd0, s.raw_humidity};

    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a = asr32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = asr32(asr32(d * d, 12) * t3, 14);
    tfine = a + b;
    r.temperature_centi = asr32(tfine * 32'd5 + 32'd128, 8);

    p1 = {48'd0, cal_plo[15:0]};
    p2 = sx16(cal_plo[31:16]);
    p3 = sx16(cal_plo[47:32]);
    p4 = sx16(cal_plo[63:48]);
    p5 = sx16(cal_phi[15:0]);
    p6 = sx16(cal_phi[31:16]);
    p7 = sx16(cal_phi[47:32]);
    p8 = sx16(cal_phi[63:48]);
    p9 = sx16(cal_mixed[15:0]);
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    nv1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + nv1) * p1, 33);
    if (v1 == 64'd0) begin
      r.pressure_q24_8 = '0;
      r.pressure_valid = 1'b0;
    end else begin
      p  = 64'd1048576 - adc_p;
      p  = sdiv64(((p << 31) - v2) * 64'd3125, v1);
      ps = asr64(p, 13);
      nv1 = asr64(p9 * ps * ps, 25);
      v2 = asr64(p8 * p, 19);
      p  = asr64(p + nv1 + v2, 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end

    r.humidity_q22_10 = '0;
    if (cal_has_hum) begin
      h1 = {24'd0, cal_mixed[23:16]};
      h2 = {{16{cal_mixed[39]}}, cal_mixed[39:24]};
      h3 = {24'd0, cal_mixed[47:40]};
      h4 = {{20{cal_hum[11]}}, cal_hum[11:0]};
      h5 = {{20{cal_hum[23]}}, cal_hum[23:12]};
      h6 = {{24{cal_hum[31]}}, cal_hum[31:24]};
      hv = tfine - 32'd76800;
      hx = asr32((adc_h << 14) - (h4 << 20) - (h5 * hv) + 32'd16384, 15);
      hy = asr32(hv * h6, 10) * (asr32(hv * h3, 11) + 32'd32768);
      hy = asr32(hy, 10) + 32'd2097152;
      hy = asr32(hy * h2 + 32'd8192, 14);
      hv = hx * hy;
      hs = asr32(hv, 15);
      hv = hv - asr32(asr32(hs * hs, 7) * h1, 4);
      if (hv[31]) hv = '0;
      else if (hv > 32'd419430400) hv = 32'd419430400;
      r.humidity_q22_10 = 17'(hv >> 12);
    end
    r.humidity_valid = cal_has_hum;
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        expected_readings.push_back(compensate(pending_samples.pop_front()));
      end
      if (pending_samples.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
        req_if.valid <= 1'b1;
        req_if.data  <= pending_samples[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  int unsigned hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, g;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        g = res_if.data;
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, g);
        end else begin
          e = expected_readings.pop_front();
          if (g.temperature_centi !== e.temperature_centi) begin
            errors++;
            $display("%0t: temperature exp %0d got %0d", $time,
                     e.temperature_centi, g.temperature_centi);
          end
          if (g.pressure_q24_8 !== e.pressure_q24_8) begin
            errors++;
            $display("%0t: pressure exp %h got %h", $time, e.pressure_q24_8, g.pressure_q24_8);
          end
          if (g.pressure_valid !== e.pressure_valid) begin
            errors++;
            $display("%0t: pressure_valid exp %b got %b", $time,
                     e.pressure_valid, g.pressure_valid);
          end
          if (g.humidity_q22_10 !== e.humidity_q22_10) begin
            errors++;
            $display("%0t: humidity exp %0d got %0d", $time,
                     e.humidity_q22_10, g.humidity_q22_10);
          end
          if (g.humidity_valid !== e.humidity_valid) begin
            errors++;
            $display("%0t: humidity_valid exp %b got %b", $time,
                     e.humidity_valid, g.humidity_valid);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        res_if.ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        // long back-pressure so the pipeline fills and stalls requests
        hold_cnt <= HoldCycles;
        hold_done <= 1'b1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || $urandom_range(99) >= 17;
      end
    end
  end

  // watchdog
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_HAS_HUM:  cal_has_hum = val[0];
      CFG_TEMP:     cal_temp    = val[47:0];
      CFG_PRESS_LO: cal_plo     = val;
      CFG_PRESS_HI: cal_phi     = val;
      CFG_MIXED:    cal_mixed   = val[47:0];
      CFG_HUM:      cal_hum     = val[31:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cal(input logic hh, input logic [47:0] t, input logic [63:0] pl,
                          input logic [63:0] ph, input logic [47:0] m,
                          input logic [31:0] h);
    write_reg(CFG_HAS_HUM, {{63{~hh}}, hh});  // upper bits are don't-care
    write_reg(CFG_TEMP, {16'hA5A5, t});
    write_reg(CFG_PRESS_LO, pl);
    write_reg(CFG_PRESS_HI, ph);
    write_reg(CFG_MIXED, {16'h5A5A, m});
    write_reg(CFG_HUM, {32'hFFFF_0000, h});
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !req_if.valid && expected_readings.size() == 0);
    repeat (TotalLat + 4) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_sample();
    in_item_t s;
    s.raw_temperature = 20'($urandom);
    s.raw_pressure    = 20'($urandom);
    s.raw_humidity    = 16'($urandom);
    // most samples near typical room conditions
    if ($urandom_range(3) != 0) begin
      s.raw_temperature = 20'($urandom_range(560000, 480000));
      s.raw_pressure    = 20'($urandom_range(450000, 250000));
      s.raw_humidity    = 16'($urandom_range(40000, 20000));
    end
    return s;
  endfunction

  task automatic push_random(input int n);
    repeat (n) pending_samples.push_back(rand_sample());
  endtask

  task automatic push_directed();
    in_item_t s;
    for (int i = 0; i < 8; i++) begin
      s.raw_temperature = i[0] ? 20'hFFFFF : 20'h0;
      s.raw_pressure    = i[1] ? 20'hFFFFF : 20'h0;
      s.raw_humidity    = i[2] ? 16'hFFFF : 16'h0;
      pending_samples.push_back(s);
    end
    s = '{20'h55555, 20'hAAAAA, 16'h5555};
    pending_samples.push_back(s);
    s = '{20'hAAAAA, 20'h55555, 16'hAAAA};
    pending_samples.push_back(s);
    s = '{20'd519888, 20'd415148, 16'd30000};
    pending_samples.push_back(s);
  endtask

  // typical datasheet-style calibration words
  localparam logic [47:0] TypT  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypPL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TypPH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [47:0] TypM  = {8'd0, 16'd362, 8'd75, 16'd6000};
  localparam logic [31:0] TypH  = {8'd30, 12'd50, 12'd313};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: pressure divisor is zero
    push_directed();
    push_random(80);
    drain();

    // typical calibration with back-pressure burst
    load_cal(1'b1, TypT, TypPL, TypPH, TypM, TypH);
    write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd7, 64'h1234_5678_9ABC_DEF0);
    push_directed();
    hold_go = 1'b1;
    push_random(500);
    drain();

    // no idling stretch, pressure-only variant
    no_idle = 1'b1;
    load_cal(1'b0, TypT, TypPL, TypPH, TypM, TypH);
    push_directed();
    push_random(250);
    drain();
    no_idle = 1'b0;

    // all ones
    load_cal(1'b1, '1, '1, '1, '1, '1);
    push_directed();
    push_random(150);
    drain();

    // random calibration sets
    repeat (4) begin
      load_cal(1'($urandom), 48'({$urandom, $urandom}), {$urandom, $urandom},
               {$urandom, $urandom}, 48'({$urandom, $urandom}), $urandom);
      push_random(160);
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sensor_reading_compensation_top.f =====
rtl/core/scomp_pkg.sv
rtl/core/scomp_stream_if.sv
rtl/core/scomp_delay.sv
rtl/core/scomp_temp.sv
rtl/core/scomp_hum.sv
rtl/core/scomp_div.sv
rtl/core/scomp_press.sv
rtl/core/sensor_reading_compensation_top.sv
dv/tb_sensor_reading_compensation_top.sv
